FILE: src/lmb_pkg.sv
package lmb_pkg;

  localparam int MAX_SIZE = 1024;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int SIZE_W   = 11;
  localparam int PIX_W    = 8;
  localparam int COL_W    = PIX_W + 2;
  localparam int SUM_W    = PIX_W + 4;
  localparam int RES_MAX  = 4;
  localparam int QDEPTH   = 8;
  localparam int QPTR_W   = $clog2(QDEPTH);

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             above;
    logic             done;
  } result_t;

  typedef struct packed {
    logic [PIX_W-1:0] t;
    logic [PIX_W-1:0] m;
    logic [PIX_W-1:0] b;
  } column_t;

endpackage

FILE: src/lmb_result_queue.sv
module lmb_result_queue import lmb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [RES_MAX-1:0]    push_mask,
  input  result_t [RES_MAX-1:0] push_items,
  input  logic                  pop,
  output result_t               head,
  output logic                  nonempty,
  output logic [QPTR_W:0]       level
);

  result_t            q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic [QPTR_W:0]    pos [RES_MAX+1];
  logic [QPTR_W-1:0]  slot [RES_MAX];

  // valid results are packed into consecutive slots, in order
  always_comb begin
    pos[0] = '0;
    for (int k = 0; k < RES_MAX; k++) begin
      pos[k+1] = pos[k] + (QPTR_W+1)'(push_mask[k]);
      slot[k]  = wr_ptr + pos[k][QPTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_MAX; k++) begin
      if (push_mask[k]) begin
        q[slot[k]] <= push_items[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + pos[RES_MAX][QPTR_W-1:0];
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + pos[RES_MAX] - (QPTR_W+1)'(pop);
    end
  end

  assign head     = q[rd_ptr];
  assign nonempty = (count != '0);
  assign level    = count;

endmodule

FILE: src/local_mean_binarize_3x3.sv
// Local mean binarizer, 3x3 window with mirrored borders.
// Input channel: pixel with in_valid/in_stall, square image in raster order.
// Output channel: out_row, out_col, above_mean, image_done with
// out_valid/out_stall; above_mean is 1 when 9*pixel exceeds the window sum.
// Config: cfg_we/cfg_data set the image side (clamped to 2..1024) and
// restart the image at pixel (0,0). Write only while the block is idle.
// Pixel (r,c) yields the result for (r-1,c-1); the row end and the last row
// yield extra results, up to four for the final pixel of an image.
// Results are computed from stage s1 and written into the result queue.
// Throughput: one pixel per cycle while in_stall is low, set by the line
// store, which is read and written back once per pixel (one read port, one
// write port). Pixels that yield two or more results are limited by the
// one-per-cycle output rate, so in_stall holds back the last row.
// An 8-entry result queue decouples the sides; in_stall rises when it cannot
// take the worst case of the next pixel. A stalled output holds its item.
// Reset: image side 1024, position (0,0), queue empty. Line store contents
// are not cleared; only rows of the current image are ever used.
module local_mean_binarize_3x3 import lmb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_row,
  output logic [IDX_W-1:0]  out_col,
  output logic              above_mean,
  output logic              image_done
);

  // line store word: {row r-1, row r-2} at each column
  logic [2*PIX_W-1:0] line_mem [MAX_SIZE];
  logic [2*PIX_W-1:0] rd_data;

  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] row_count;
  logic [IDX_W-1:0] col_count;

  logic               s1_valid;
  logic [IDX_W-1:0]   s1_row;
  logic [IDX_W-1:0]   s1_col;
  logic [PIX_W-1:0]   s1_pix;
  logic [RES_MAX-1:0] s1_mask;
  logic [2:0]         s1_cnt;
  logic               s1_top_refl;
  logic               s1_left_refl;

  column_t win_m;
  column_t win_l;

  logic               in_acc;
  logic               fa, fb, fc, fd;
  logic [QPTR_W:0]    q_level;
  logic [QPTR_W+1:0]  need;
  logic               pop;
  result_t            head;

  column_t                col_r;
  column_t                col_l;
  logic [COL_W-1:0]       sa_l, sa_m, sa_r, sc_l, sc_m, sc_r;
  logic [SUM_W-1:0]       sum_a, sum_b, sum_c, sum_d;
  result_t [RES_MAX-1:0]  res;
  logic [RES_MAX-1:0]     push_mask;

  function automatic logic [COL_W-1:0] sum_up(column_t x, logic refl);
    logic [PIX_W-1:0] up;
    up = refl ? x.b : x.t;
    return COL_W'(up) + COL_W'(x.m) + COL_W'(x.b);
  endfunction

  function automatic logic [COL_W-1:0] sum_last(column_t x);
    return {1'b0, x.m, 1'b0} + COL_W'(x.b);
  endfunction

  function automatic logic [SUM_W-1:0] times9(logic [PIX_W-1:0] p);
    return {1'b0, p, 3'b000} + SUM_W'(p);
  endfunction

  assign need     = {1'b0, q_level} + (QPTR_W+2)'(s1_cnt);
  assign in_stall = need > (QPTR_W+2)'(QDEPTH - RES_MAX);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    fa = (row_count != '0) && (col_count != '0);
    fb = fa && (col_count == last_idx);
    fc = (row_count == last_idx) && (col_count != '0);
    fd = fc && (col_count == last_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_idx  <= IDX_W'(MAX_SIZE - 1);
      row_count <= '0;
      col_count <= '0;
    end else if (cfg_we) begin
      if (cfg_data < SIZE_W'(2)) begin
        last_idx <= IDX_W'(1);
      end else if (cfg_data > SIZE_W'(MAX_SIZE)) begin
        last_idx <= IDX_W'(MAX_SIZE - 1);
      end else begin
        last_idx <= IDX_W'(cfg_data - SIZE_W'(1));
      end
      row_count <= '0;
      col_count <= '0;
    end else if (in_acc) begin
      if (col_count == last_idx) begin
        col_count <= '0;
        row_count <= (row_count == last_idx) ? '0 : row_count + IDX_W'(1);
      end else begin
        col_count <= col_count + IDX_W'(1);
      end
    end
  end

  // read at accept, write back in the next cycle from stage s1; consecutive
  // pixels never share a column, so the two accesses cannot collide
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data <= line_mem[col_count];
    end
    if (s1_valid) begin
      line_mem[s1_col] <= {s1_pix, rd_data[2*PIX_W-1:PIX_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_mask  <= '0;
      s1_cnt   <= '0;
    end else begin
      s1_valid <= in_acc;
      s1_mask  <= in_acc ? {fd, fc, fb, fa} : '0;
      s1_cnt   <= in_acc ? 3'(fa) + 3'(fb) + 3'(fc) + 3'(fd) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_row       <= row_count;
      s1_col       <= col_count;
      s1_pix       <= pixel;
      s1_top_refl  <= (row_count == IDX_W'(1));
      s1_left_refl <= (col_count == IDX_W'(1));
    end
    if (s1_valid) begin
      win_l <= win_m;
      win_m <= col_r;
    end
  end

  always_comb begin
    col_r.t = rd_data[PIX_W-1:0];
    col_r.m = rd_data[2*PIX_W-1:PIX_W];
    col_r.b = s1_pix;
    col_l   = s1_left_refl ? col_r : win_l;

    sa_l = sum_up(col_l, s1_top_refl);
    sa_m = sum_up(win_m, s1_top_refl);
    sa_r = sum_up(col_r, s1_top_refl);
    sc_l = sum_last(col_l);
    sc_m = sum_last(win_m);
    sc_r = sum_last(col_r);

    sum_a = SUM_W'(sa_l) + SUM_W'(sa_m) + SUM_W'(sa_r);
    sum_b = {1'b0, sa_m, 1'b0} + SUM_W'(sa_r);
    sum_c = SUM_W'(sc_l) + SUM_W'(sc_m) + SUM_W'(sc_r);
    sum_d = {1'b0, sc_m, 1'b0} + SUM_W'(sc_r);

    res[0].row   = s1_row - IDX_W'(1);
    res[0].col   = s1_col - IDX_W'(1);
    res[0].above = times9(win_m.m) > sum_a;
    res[0].done  = 1'b0;

    res[1].row   = s1_row - IDX_W'(1);
    res[1].col   = s1_col;
    res[1].above = times9(col_r.m) > sum_b;
    res[1].done  = 1'b0;

    res[2].row   = s1_row;
    res[2].col   = s1_col - IDX_W'(1);
    res[2].above = times9(win_m.b) > sum_c;
    res[2].done  = 1'b0;

    res[3].row   = s1_row;
    res[3].col   = s1_col;
    res[3].above = times9(col_r.b) > sum_d;
    res[3].done  = 1'b1;

    push_mask = s1_valid ? s1_mask : '0;
  end

  lmb_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_mask  (push_mask),
    .push_items (res),
    .pop        (pop),
    .head       (head),
    .nonempty   (out_valid),
    .level      (q_level)
  );

  assign pop        = out_valid && !out_stall;
  assign out_row    = head.row;
  assign out_col    = head.col;
  assign above_mean = head.above;
  assign image_done = head.done;

endmodule

FILE: sim/local_mean_binarize_3x3_test.sv
module local_mean_binarize_3x3_test;
  import lmb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [PIX_W-1:0]  pixel;
  logic              out_valid;
  logic              out_stall;
  logic [IDX_W-1:0]  out_row;
  logic [IDX_W-1:0]  out_col;
  logic              above_mean;
  logic              image_done;

  class mean_threshold_board;
    logic [PIX_W-1:0] rows_seen [3][MAX_SIZE];
    int               side;
    int               row_at;
    int               col_at;
    result_t          awaited[$];
    int               errors;
    int               checked;

    function new();
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < MAX_SIZE; j++) begin
          rows_seen[i][j] = '0;
        end
      end
      side = MAX_SIZE;
      row_at = 0;
      col_at = 0;
      errors = 0;
      checked = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_side(logic [SIZE_W-1:0] code);
      side = int'(code);
      if (side < 2) side = 2;
      if (side > MAX_SIZE) side = MAX_SIZE;
      row_at = 0;
      col_at = 0;
    endfunction

    function int mirror(int idx);
      if (idx < 0) return 1;
      if (idx >= side) return side - 2;
      return idx;
    endfunction

    function logic window_above(int r, int c);
      int sum;
      int rr;
      sum = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        rr = mirror(r + dr) % 3;
        for (int dc = -1; dc <= 1; dc++) begin
          sum += int'(rows_seen[rr][mirror(c + dc)]);
        end
      end
      return (9 * int'(rows_seen[r % 3][c]) > sum);
    endfunction

    function void add_result(int r, int c, logic last);
      result_t e;
      e.row = IDX_W'(r);
      e.col = IDX_W'(c);
      e.above = window_above(r, c);
      e.done = last;
      awaited.push_back(e);
    endfunction

    function void take_pixel(logic [PIX_W-1:0] v);
      int r;
      int c;
      r = row_at;
      c = col_at;
      if (r >= side || c >= side) begin
        r = 0;
        c = 0;
      end
      rows_seen[r % 3][c] = v;
      if (r >= 1 && c >= 1) begin
        add_result(r - 1, c - 1, 1'b0);
        if (c == side - 1) add_result(r - 1, side - 1, 1'b0);
      end
      if (r == side - 1 && c >= 1) begin
        add_result(r, c - 1, 1'b0);
        if (c == side - 1) add_result(r, side - 1, 1'b1);
      end
      c++;
      if (c >= side) begin
        c = 0;
        r++;
        if (r >= side) r = 0;
      end
      row_at = r;
      col_at = c;
    endfunction

    task match_result(result_t got);
      result_t e;
      if (awaited.size() == 0) begin
        report($sformatf("result with none expected: row %0d col %0d",
                         got.row, got.col));
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (got.row !== e.row)
        report($sformatf("out_row %0d, expected %0d", got.row, e.row));
      if (got.col !== e.col)
        report($sformatf("out_col %0d, expected %0d (row %0d)", got.col, e.col, e.row));
      if (got.above !== e.above)
        report($sformatf("above_mean %0b, expected %0b at (%0d,%0d)",
                         got.above, e.above, e.row, e.col));
      if (got.done !== e.done)
        report($sformatf("image_done %0b, expected %0b at (%0d,%0d)",
                         got.done, e.done, e.row, e.col));
    endtask
  endclass

  mean_threshold_board board;
  bit no_idle;
  bit hold_req;
  int pixels_in;
  int sizes_used;

  local_mean_binarize_3x3 dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .above_mean (above_mean),
    .image_done (image_done)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 120;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.row = out_row;
      got.col = out_col;
      got.above = above_mean;
      got.done = image_done;
      board.match_result(got);
    end
  end

  // entered and left at a falling edge; in_valid stays high on return
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_pixel(v);
    pixels_in++;
    @(negedge clk);
  endtask

  task automatic send_run(input int count, input bit flat);
    int base;
    int d;
    logic [PIX_W-1:0] v;
    base = $urandom_range(0, 255);
    for (int k = 0; k < count; k++) begin
      if (flat) begin
        d = base + $urandom_range(0, 4) - 2;
        if (d < 0) d = 0;
        if (d > 255) d = 255;
        v = PIX_W'(d);
      end else begin
        v = PIX_W'($urandom);
      end
      send_pixel(v);
    end
    in_valid <= 1'b0;
  endtask

  task automatic await_quiet();
    while (board.awaited.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_side(input logic [SIZE_W-1:0] code);
    cfg_we <= 1'b1;
    cfg_data <= code;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_side(code);
    sizes_used++;
  endtask

  initial begin
    #4000000;
    $display("timeout: %0d results still expected", board.awaited.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int sz;
    int count;
    int random_sent;
    logic [SIZE_W-1:0] code;
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    pixels_in = 0;
    sizes_used = 0;
    random_sent = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset size 1024: start of the first row, nothing resolves yet
    send_run(16, 1'b0);
    await_quiet();

    // 2x2 image, size written as 0 (clamped)
    write_side('0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    in_valid <= 1'b0;
    await_quiet();

    // flat image: pixel equals mean, never above
    write_side(SIZE_W'(1));
    repeat (4) send_pixel(8'd255);
    in_valid <= 1'b0;
    await_quiet();

    write_side(SIZE_W'(3));
    for (int k = 0; k < 9; k++) send_pixel((k % 2) ? 8'd255 : 8'd0);
    in_valid <= 1'b0;
    await_quiet();

    // partial image, then a write restarts at (0,0)
    write_side(SIZE_W'(4));
    for (int k = 0; k < 6; k++) send_pixel(PIX_W'(k * 51));
    in_valid <= 1'b0;
    await_quiet();

    // long output hold-off while input keeps coming
    write_side(SIZE_W'(6));
    no_idle = 1'b1;
    hold_req = 1'b1;
    send_run(36, 1'b0);
    no_idle = 1'b0;
    await_quiet();

    while (random_sent < 50) begin
      sz = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(2, 8);
      code = SIZE_W'(sz);
      if (sz == 2 && $urandom_range(0, 1) == 1) code = SIZE_W'($urandom_range(0, 1));
      write_side(code);
      no_idle = ($urandom_range(0, 3) == 0);
      count = ((sz > 8) ? 1 : $urandom_range(1, 2)) * sz * sz;
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count - 1);
      send_run(count, $urandom_range(0, 2) == 0);
      random_sent += count;
      no_idle = 1'b0;
      await_quiet();
    end

    // oversize code clamps to 1024; start of the first row only
    write_side(SIZE_W'(2047));
    send_run(16, 1'b0);
    await_quiet();

    $display("run: %0d pixels in, %0d results checked, %0d size writes",
             pixels_in, board.checked, sizes_used);
    $display("sizes 2..12 with clamped codes, first row at 1024, restarts, long output hold");
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
